@@ hdl/adsr_pkg.sv @@
// adsr envelope generator shared widths, fixed-point constants and codes
`default_nettype none

package adsr_pkg;

  // fixed field widths
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned CURVE_W    = 2;
  localparam int unsigned SEG_W      = 2;
  localparam int unsigned PROD_W     = 32;

  // level format: unsigned with FRAC_BITS fraction bits, ONE = 1.0
  localparam int unsigned FRAC_BITS  = 15;
  localparam logic [LEVEL_W-1:0] ONE  = LEVEL_W'(1 << FRAC_BITS);
  localparam logic [LEVEL_W-1:0] HALF = LEVEL_W'(1 << (FRAC_BITS - 1));

  // rounding constant for q0.16 factor multiplies
  localparam logic [PROD_W-1:0] FACTOR_RND = PROD_W'(1 << (FACTOR_W - 1));

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ATTACK_LEN     = 3'd0;
  localparam cfg_idx_t REG_GATE_LEN       = 3'd1;
  localparam cfg_idx_t REG_TOTAL_LEN      = 3'd2;
  localparam cfg_idx_t REG_SUSTAIN_LEVEL  = 3'd3;
  localparam cfg_idx_t REG_ATTACK_FACTOR  = 3'd4;
  localparam cfg_idx_t REG_DECAY_FACTOR   = 3'd5;
  localparam cfg_idx_t REG_RELEASE_FACTOR = 3'd6;
  localparam cfg_idx_t REG_CURVE_ENABLE   = 3'd7;

  // curve_enable bits
  localparam int unsigned CURVE_DECAY_BIT   = 0;
  localparam int unsigned CURVE_RELEASE_BIT = 1;

  // segment codes
  typedef logic [SEG_W-1:0] seg_t;

  localparam seg_t SEG_ATTACK  = 2'd0;
  localparam seg_t SEG_DECAY   = 2'd1;
  localparam seg_t SEG_RELEASE = 2'd2;
  localparam seg_t SEG_IDLE    = 2'd3;

  // register reset values
  localparam logic [LEN_W-1:0]   RST_ATTACK_LEN   = 24'd0;
  localparam logic [LEN_W-1:0]   RST_GATE_LEN     = 24'd44100;
  localparam logic [LEN_W-1:0]   RST_TOTAL_LEN    = 24'd176400;
  localparam logic [CURVE_W-1:0] RST_CURVE_ENABLE = 2'd3;

endpackage

`default_nettype wire

@@ hdl/adsr_envelope_generator.sv @@
// adsr envelope generator: exponential attack/decay/sustain/release, one sample per item
//
// usage: each item on the input channel is one sample tick. in_restart = 1 starts a
// new note at sample zero on that tick, 0 lets the running note advance by one sample.
// every item gives exactly one result item: out_level (q1.15 unsigned), out_segment
// (attack, decay/sustain, release, idle) and out_final_sample on the last sample.
// configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while no item is in flight (not enforced by the block); writes take
// effect at the next item. the result register loads at the edge that accepts the item.
// throughput: 1 item per cycle while the result register is not stalled. the envelope
// state (sample count, curve term, last level) updates at every accepted item through
// one pass of compare/multiply-add logic, so the next item sees the updated state.
// stall: the result register holds its item while out_stall is high; in_stall rises
// only when that register is full and stalled, so a new item enters in the same cycle
// the old result is taken.
// reset: rst_n low (synchronous) empties the result register, stops any note (idle, so
// later items give level 0 / segment idle) and loads the register reset values.
`default_nettype none

module adsr_envelope_generator
  import adsr_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_restart,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LEVEL_W-1:0]         out_level,
  output logic [SEG_W-1:0]           out_segment,
  output logic                       out_final_sample
);

  // compare width covers both the length registers and the sample index plus one
  localparam int unsigned CMP_W = (INDEX_BITS + 1 > LEN_W) ? INDEX_BITS + 1 : LEN_W;

  // configuration registers
  logic [LEN_W-1:0]    attack_len_r;
  logic [LEN_W-1:0]    gate_len_r;
  logic [LEN_W-1:0]    total_len_r;
  logic [LEVEL_W-1:0]  sustain_level_r;
  logic [FACTOR_W-1:0] attack_factor_r;
  logic [FACTOR_W-1:0] decay_factor_r;
  logic [FACTOR_W-1:0] release_factor_r;
  logic [CURVE_W-1:0]  curve_enable_r;

  // envelope state
  logic [INDEX_BITS-1:0] sample_count_r, sample_count_nxt;
  logic [LEVEL_W-1:0]    curve_term_r, curve_term_nxt;
  logic [LEVEL_W-1:0]    last_level_r, last_level_nxt;
  logic                  active_r, active_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]    out_level_r, out_level_nxt;
  seg_t                  out_segment_r, out_segment_nxt;
  logic                  out_final_r, out_final_nxt;

  logic                  in_accept;

  // state as seen by this sample, after a possible restart
  logic [INDEX_BITS-1:0] n_eff;
  logic [LEVEL_W-1:0]    ct_eff;
  logic [LEVEL_W-1:0]    ll_eff;
  logic                  act_eff;

  logic [CMP_W-1:0]      n_x, n1_x, att_x, gate_x, tot_x;
  logic                  in_release, in_attack;

  logic [LEVEL_W-1:0]    sus_sat;
  logic [LEVEL_W-1:0]    sus_gap;
  logic [FACTOR_W-1:0]   ct_factor;
  logic [PROD_W-1:0]     ct_prod;
  logic [PROD_W-1:0]     rel_prod;
  logic [PROD_W-1:0]     dec_prod;
  logic [LEVEL_W-1:0]    ct_scaled;
  logic [LEVEL_W-1:0]    rel_level;
  logic [LEVEL_W-1:0]    dec_level;

  // ---------------------------------------------------------------- handshake
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_segment      = out_segment_r;
  assign out_final_sample = out_final_r;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r     <= RST_ATTACK_LEN;
      gate_len_r       <= RST_GATE_LEN;
      total_len_r      <= RST_TOTAL_LEN;
      sustain_level_r  <= '0;
      attack_factor_r  <= '0;
      decay_factor_r   <= '0;
      release_factor_r <= '0;
      curve_enable_r   <= RST_CURVE_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_LEN:     attack_len_r     <= cfg_wdata[LEN_W-1:0];
        REG_GATE_LEN:       gate_len_r       <= cfg_wdata[LEN_W-1:0];
        REG_TOTAL_LEN:      total_len_r      <= cfg_wdata[LEN_W-1:0];
        REG_SUSTAIN_LEVEL:  sustain_level_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_ATTACK_FACTOR:  attack_factor_r  <= cfg_wdata[FACTOR_W-1:0];
        REG_DECAY_FACTOR:   decay_factor_r   <= cfg_wdata[FACTOR_W-1:0];
        REG_RELEASE_FACTOR: release_factor_r <= cfg_wdata[FACTOR_W-1:0];
        REG_CURVE_ENABLE:   curve_enable_r   <= cfg_wdata[CURVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- sample datapath
  // restart forces a fresh note: index zero, curve term one, previous level zero
  assign n_eff   = in_restart ? '0  : sample_count_r;
  assign ct_eff  = in_restart ? ONE : curve_term_r;
  assign ll_eff  = in_restart ? '0  : last_level_r;
  assign act_eff = in_restart | active_r;

  assign n_x    = CMP_W'(n_eff);
  assign n1_x   = n_x + CMP_W'(1);
  assign att_x  = CMP_W'(attack_len_r);
  assign gate_x = CMP_W'(gate_len_r);
  assign tot_x  = CMP_W'(total_len_r);

  // release wins over attack when the gate falls inside the attack
  assign in_release = (n_x >= gate_x);
  assign in_attack  = ~in_release & (n_x < att_x);

  assign sus_sat = (sustain_level_r > ONE) ? ONE : sustain_level_r;
  assign sus_gap = ONE - sus_sat;

  // curve term recursion: one shared multiply, factor picked by segment
  assign ct_factor = in_attack ? attack_factor_r : decay_factor_r;
  assign ct_prod   = PROD_W'(ct_eff) * PROD_W'(ct_factor) + FACTOR_RND;
  assign ct_scaled = ct_prod[FACTOR_W +: LEVEL_W];

  // release: previous level times the per-sample factor
  assign rel_prod  = PROD_W'(ll_eff) * PROD_W'(release_factor_r) + FACTOR_RND;
  assign rel_level = rel_prod[FACTOR_W +: LEVEL_W];

  // decay: s + (one - s) * x, rounded
  assign dec_prod  = PROD_W'(sus_gap) * PROD_W'(ct_eff) + PROD_W'(HALF);
  assign dec_level = sus_sat + dec_prod[FRAC_BITS +: LEVEL_W];

  always_comb begin
    sample_count_nxt = n_eff;
    curve_term_nxt   = ct_eff;
    last_level_nxt   = ll_eff;
    active_nxt       = act_eff;
    out_level_nxt    = '0;
    out_segment_nxt  = SEG_IDLE;
    out_final_nxt    = 1'b0;

    if (act_eff) begin
      if (n_x >= tot_x) begin
        // note already over, or zero total length
        active_nxt = 1'b0;
      end else begin
        if (in_release) begin
          out_segment_nxt = SEG_RELEASE;
          out_level_nxt   = curve_enable_r[CURVE_RELEASE_BIT] ? rel_level : '0;
        end else if (in_attack) begin
          out_segment_nxt = SEG_ATTACK;
          out_level_nxt   = ONE - ct_eff;
          // last attack sample hands a fresh term to the decay
          curve_term_nxt  = (n1_x == att_x) ? ONE : ct_scaled;
        end else begin
          out_segment_nxt = SEG_DECAY;
          if (curve_enable_r[CURVE_DECAY_BIT]) begin
            out_level_nxt  = dec_level;
            curve_term_nxt = ct_scaled;
          end else begin
            out_level_nxt  = sus_sat;
          end
        end
        last_level_nxt = out_level_nxt;
        if (n1_x == tot_x) begin
          out_final_nxt = 1'b1;
          active_nxt    = 1'b0;
        end
        sample_count_nxt = n1_x[INDEX_BITS-1:0];
      end
    end
  end

  assign out_valid_nxt = in_accept | (out_valid_r & out_stall);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      curve_term_r   <= ONE;
      last_level_r   <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        sample_count_r <= sample_count_nxt;
        curve_term_r   <= curve_term_nxt;
        last_level_r   <= last_level_nxt;
        active_r       <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_level_r   <= out_level_nxt;
      out_segment_r <= out_segment_nxt;
      out_final_r   <= out_final_nxt;
    end
  end

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  // an accepted item always shows up in the result register next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item did not reach the result register");

  // the input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a stalled result");

  // idle results carry zero level and never flag the final sample
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_segment_r == SEG_IDLE) |-> (out_level_r == '0 && !out_final_r))
    else $error("idle result with nonzero level or final flag");

  // after the final sample the note is stopped
  a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && out_final_nxt) |=> !active_r)
    else $error("note still active after its final sample");
`endif

endmodule

`default_nettype wire
